// ===== rtl/core/auto_radix_number_parser_assert.svh =====
// Assertion macros for the checker of the number parser.
`ifndef AUTO_RADIX_NUMBER_PARSER_ASSERT_SVH
`define AUTO_RADIX_NUMBER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ARNP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("number parser assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ARNP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("number parser assertion failed");

`endif

// ===== rtl/core/arnp_pkg.sv =====
// Package with the types and codes of the auto-radix number parser.
package arnp_pkg;

	// Parse phase, one-hot.
	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_ZERO  = 5'b00010,
		PH_DEC   = 5'b00100,
		PH_OCT   = 5'b01000,
		PH_HEX   = 5'b10000
	} phase_t;

	// Radix codes as they appear on the result channel.
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	typedef struct packed {
		logic [31:0] acc;
		phase_t      phase;
		logic        illegal;
	} state_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  radix_code;
		logic        illegal_seen;
	} result_t;

	localparam state_t STATE_RESET = '{acc: 32'd0, phase: PH_START, illegal: 1'b0};

endpackage

// ===== rtl/core/arnp_if.sv =====
// Valid/ready channel interfaces for characters in and parsed numbers out.
interface arnp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;

	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface arnp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [1:0]  radix_code;
	logic        illegal_seen;

	modport source (output valid, output value, output radix_code, output illegal_seen,
		input ready);
	modport sink (input valid, input value, input radix_code, input illegal_seen,
		output ready);
endinterface

// ===== rtl/core/arnp_step.sv =====
// Next-state and result logic for one character of the number parser.
module arnp_step (
	input  arnp_pkg::state_t  cur,
	input  logic [7:0]        ch,
	output arnp_pkg::state_t  nxt,
	output logic              emit,
	output arnp_pkg::result_t res
);
	import arnp_pkg::*;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_LX  = 8'h78;

	logic [1:0]  dig_radix;
	logic        ok;
	logic [3:0]  digit;
	logic [31:0] scaled;
	logic [31:0] stepped;

	// Radix in force for a digit in this phase; also the reported code.
	always_comb begin
		case (cur.phase)
			PH_HEX:          dig_radix = RADIX_HEX;
			PH_ZERO, PH_OCT: dig_radix = RADIX_OCT;
			default:         dig_radix = RADIX_DEC;
		endcase
	end

	// Digit decode and accumulator scaling by shifts and one add.
	always_comb begin
		digit = ch[3:0];
		case (dig_radix)
			RADIX_HEX: begin
				ok = ch inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
				if (!(ch inside {[CH_0:CH_9]}))
					digit = 4'(ch[3:0] + 4'd9);
				scaled = {cur.acc[27:0], 4'b0000};
			end
			RADIX_OCT: begin
				ok = ch inside {[CH_0:CH_7]};
				scaled = {cur.acc[28:0], 3'b000};
			end
			default: begin
				ok = ch inside {[CH_0:CH_9]};
				scaled = {cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0};
			end
		endcase
		stepped = scaled + {28'd0, digit};
	end

	always_comb begin
		logic take;
		take = 1'b0;
		nxt = cur;
		emit = 1'b0;
		res.value = cur.acc;
		res.radix_code = dig_radix;
		res.illegal_seen = cur.illegal;
		if (ch == CH_NUL) begin
			emit = 1'b1;
			nxt = STATE_RESET;
		end else begin
			case (cur.phase)
				PH_ZERO: begin
					if (ch == CH_LX || ch == CH_UX) begin
						nxt.phase = PH_HEX;
					end else begin
						nxt.phase = PH_OCT;
						take = 1'b1;
					end
				end
				PH_DEC, PH_OCT, PH_HEX: begin
					take = 1'b1;
				end
				default: begin
					// Start phase, and any stray code treated as start.
					if (ch == CH_0) begin
						nxt.phase = PH_ZERO;
					end else begin
						nxt.phase = PH_DEC;
						take = 1'b1;
					end
				end
			endcase
			if (take) begin
				if (ok)
					nxt.acc = stepped;
				else
					nxt.illegal = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/auto_radix_number_parser.sv =====
// Top level of the auto-radix number parser: input stage, parse state, result register.
//
// The block takes one ASCII character per transaction and parses an unsigned number whose
// radix comes from its prefix: "0x" or "0X" selects hexadecimal, a lone leading "0" selects
// octal, anything else decimal. Each legal digit updates the value as value * radix + digit,
// wrapping modulo 2^32; an illegal digit is skipped and sets a sticky flag. A NUL character
// ends the number and produces one result transaction carrying the value, the radix code
// (0 decimal, 1 octal, 2 hexadecimal) and the illegal flag, after which the parser is back
// in its start state. Other characters produce no result. The block accepts one character
// every clock cycle unless held back. A character is registered in the input stage and
// then moves into the parse state; the result register loads at that same edge, so a
// result is offered once its NUL has passed the input stage. The rate is set by the loop
// through the parse state register, whose update (a shift-and-add scale by the radix plus
// the digit) is combinational. The input stage keeps taking characters while a result
// waits; only a second NUL meeting a full, stalled result register holds the input back.
module auto_radix_number_parser (
	input  logic          clk,
	input  logic          arst_n,
	arnp_char_if.sink     chars,
	arnp_result_if.source result
);
	import arnp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;

	state_t  state_q;
	state_t  state_nxt;
	logic    emit;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	arnp_step u_step (
		.cur  (state_q),
		.ch   (char_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res_nxt)
	);

	// The staged character moves into the parse state unless it is a NUL whose result
	// would overwrite one that is still waiting to be taken.
	assign advance = valid_s1 && (!emit || !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready)
			char_s1 <= chars.character;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= res_nxt;
	end

	assign result.valid        = out_valid_q;
	assign result.value        = res_q.value;
	assign result.radix_code   = res_q.radix_code;
	assign result.illegal_seen = res_q.illegal_seen;

endmodule

// ===== rtl/core/arnp_checker.sv =====
// Port-level assertions for the auto-radix number parser and their bind.
module arnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  in_character,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value,
	input logic [1:0]  out_radix_code,
	input logic        out_illegal_seen
);
`include "auto_radix_number_parser_assert.svh"

	// A waiting result stays offered.
	`ARNP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// A waiting result keeps its payload.
	`ARNP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(out_value) && $stable(out_radix_code) && $stable(out_illegal_seen))

	// The input is only held back by a stalled result.
	`ARNP_ASSERT_NOW(a_in_backpressure, !in_ready, out_valid && !out_ready)

	// A NUL taken while the result side drains is on offer once it has passed the input stage.
	`ARNP_ASSERT_NEXT(a_nul_result,
		(in_valid && in_ready && in_character == 8'h00) ##1 out_ready, out_valid)

endmodule

bind auto_radix_number_parser arnp_checker u_arnp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (chars.valid),
	.in_ready         (chars.ready),
	.in_character     (chars.character),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.out_value        (result.value),
	.out_radix_code   (result.radix_code),
	.out_illegal_seen (result.illegal_seen)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the auto-radix number parser: character stream in, numbers out.
module tb_top;
	import arnp_pkg::*;

	// Characters that steer the parse.
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_0   = "0";
	localparam logic [7:0] CH_1   = "1";
	localparam logic [7:0] CH_7   = "7";
	localparam logic [7:0] CH_8   = "8";
	localparam logic [7:0] CH_9   = "9";
	localparam logic [7:0] CH_LA  = "a";
	localparam logic [7:0] CH_LF  = "f";
	localparam logic [7:0] CH_UA  = "A";
	localparam logic [7:0] CH_UF  = "F";
	localparam logic [7:0] CH_LX  = "x";
	localparam logic [7:0] CH_UX  = "X";

	localparam int unsigned RANDOM_CHARS = 1600;
	localparam int unsigned HOLD_AT      = 500;   // characters taken before the long result stall
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no transaction on either side
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PRINT_LIMIT  = 50;

	// One character of stimulus. Where typed is set on a NUL, want holds the number that
	// the row must produce; every other NUL is checked against the predictor.
	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		result_t    want;
	} stim_t;

	localparam result_t NO_RESULT = '0;

	// Directed rows: the empty string, a lone zero, both hex prefixes (one bare), a digit that is
	// illegal right after the leading zero, a late letter x, and bytes above 127.
	localparam stim_t [0:21] DIRECTED_ROWS = {
		{CH_NUL, 1'b1, 32'd0, RADIX_DEC, 1'b0},
		{CH_0,   1'b0, NO_RESULT},
		{CH_NUL, 1'b1, 32'd0, RADIX_OCT, 1'b0},
		{CH_0,   1'b0, NO_RESULT},
		{CH_LX,  1'b0, NO_RESULT},
		{CH_NUL, 1'b1, 32'd0, RADIX_HEX, 1'b0},
		{CH_0,   1'b0, NO_RESULT},
		{CH_UX,  1'b0, NO_RESULT},
		{CH_LF,  1'b0, NO_RESULT},
		{CH_NUL, 1'b0, NO_RESULT},
		{CH_0,   1'b0, NO_RESULT},
		{CH_8,   1'b0, NO_RESULT},
		{CH_NUL, 1'b1, 32'd0, RADIX_OCT, 1'b1},
		{CH_9,   1'b0, NO_RESULT},
		{CH_LX,  1'b0, NO_RESULT},
		{CH_NUL, 1'b1, 32'd9, RADIX_DEC, 1'b1},
		{8'hFF,  1'b0, NO_RESULT},
		{CH_NUL, 1'b1, 32'd0, RADIX_DEC, 1'b1},
		{CH_0,   1'b0, NO_RESULT},
		{CH_7,   1'b0, NO_RESULT},
		{8'h80,  1'b0, NO_RESULT},
		{CH_NUL, 1'b0, NO_RESULT}
	};

	logic clk = 1'b0;
	logic arst_n;

	arnp_char_if   chars_bus ();
	arnp_result_if result_bus ();

	auto_radix_number_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.result (result_bus)
	);

	always #4 clk = ~clk;

	stim_t       char_stream[$];
	result_t     expected_numbers[$];
	int unsigned chars_taken;
	int unsigned numbers_checked;
	int unsigned error_count;
	int unsigned radix_tally[3];

	// The predictor's own copy of the parse state.
	logic [31:0] pred_acc;
	phase_t      pred_phase;
	logic        pred_illegal;

	// Every mismatch goes through here: one line while the count is small, always counted.
	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// Folds one character into the predicted value as a digit of the given radix, or marks
	// it illegal when the radix does not allow it.
	task automatic accumulate_digit(input logic [7:0] c, input int unsigned radix);
		logic [4:0] digit;
		bit         ok;
		digit = '0;
		ok = 1'b0;
		if (c >= CH_0 && c <= CH_9 && (c - CH_0) < radix) begin
			digit = 5'(c - CH_0);
			ok = 1'b1;
		end else if (radix == 16 && c >= CH_LA && c <= CH_LF) begin
			digit = 5'(c - CH_LA + 8'd10);
			ok = 1'b1;
		end else if (radix == 16 && c >= CH_UA && c <= CH_UF) begin
			digit = 5'(c - CH_UA + 8'd10);
			ok = 1'b1;
		end
		if (ok) begin
			pred_acc = pred_acc * radix + digit;
		end else begin
			pred_illegal = 1'b1;
		end
	endtask

	// Advances the predicted parse by one character. A NUL yields the finished number and
	// takes the parse back to its start.
	task automatic predict_char(input logic [7:0] c, output bit emits, output result_t num);
		emits = 1'b0;
		num = '0;
		if (c == CH_NUL) begin
			emits = 1'b1;
			num.value = pred_acc;
			num.illegal_seen = pred_illegal;
			case (pred_phase)
				PH_HEX: num.radix_code = RADIX_HEX;
				PH_OCT, PH_ZERO: num.radix_code = RADIX_OCT;
				default: num.radix_code = RADIX_DEC;
			endcase
			pred_acc = '0;
			pred_phase = PH_START;
			pred_illegal = 1'b0;
		end else begin
			case (pred_phase)
				PH_ZERO: begin
					// Only x or X makes a hex prefix; anything else is the first octal digit.
					if (c == CH_LX || c == CH_UX) begin
						pred_phase = PH_HEX;
					end else begin
						pred_phase = PH_OCT;
						accumulate_digit(c, 8);
					end
				end
				PH_DEC: accumulate_digit(c, 10);
				PH_OCT: accumulate_digit(c, 8);
				PH_HEX: accumulate_digit(c, 16);
				default: begin
					if (c == CH_0) begin
						pred_phase = PH_ZERO;
					end else begin
						pred_phase = PH_DEC;
						accumulate_digit(c, 10);
					end
				end
			endcase
		end
	endtask

	function automatic logic [7:0] legal_digit(input int unsigned radix);
		int unsigned pick;
		if (radix == 16) begin
			pick = $urandom_range(0, 21);
			if (pick < 10) begin
				return 8'(CH_0 + pick);
			end else if (pick < 16) begin
				return 8'(CH_LA + pick - 10);
			end
			return 8'(CH_UA + pick - 16);
		end
		return 8'(CH_0 + $urandom_range(0, radix - 1));
	endfunction

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic add_char(input logic [7:0] c);
		char_stream.push_back({c, 1'b0, NO_RESULT});
	endtask

	// Appends one random string. Most are well formed numbers in one of the three radixes,
	// now and then with an illegal byte inside; the rest are random bytes that may or may
	// not be closed by a NUL, so the next string can start in the middle of a parse.
	task automatic add_random_string();
		int unsigned kind;
		int unsigned count;
		int unsigned radix;
		kind = $urandom_range(0, 99);
		// Long strings can push the value past 32 bits in every radix.
		count = ($urandom_range(0, 99) < 15) ? $urandom_range(9, 14) : $urandom_range(0, 8);
		if (kind < 85) begin
			if (kind < 30) begin
				add_char(8'(CH_1 + $urandom_range(0, 8)));
				radix = 10;
			end else if (kind < 55) begin
				add_char(CH_0);
				radix = 8;
			end else begin
				add_char(CH_0);
				add_char($urandom_range(0, 1) ? CH_LX : CH_UX);
				radix = 16;
			end
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 99) < 6) begin
					add_char(8'($urandom_range(1, 255)));
				end else begin
					add_char(legal_digit(radix));
				end
			end
			add_char(CH_NUL);
		end else begin
			count = $urandom_range(1, 6);
			for (int i = 0; i < count; i++) begin
				add_char(8'($urandom_range(1, 255)));
			end
			if ($urandom_range(0, 1)) begin
				add_char(CH_NUL);
			end
		end
	endtask

	// Input monitor: every accepted character goes through the predictor, and a NUL leaves
	// one expected number behind, either the one typed into its row or the predicted one.
	always @(posedge clk) begin : watch_chars
		bit      emits;
		result_t num;
		if (arst_n && chars_bus.valid && chars_bus.ready) begin
			predict_char(chars_bus.character, emits, num);
			if (emits) begin
				if (char_stream[chars_taken].typed) begin
					expected_numbers.push_back(char_stream[chars_taken].want);
				end else begin
					expected_numbers.push_back(num);
				end
			end
			chars_taken++;
		end
	end

	// Result checker: each accepted number is compared field by field with the oldest one
	// still expected.
	always @(posedge clk) begin : check_numbers
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_numbers.size() == 0) begin
				report_mismatch($sformatf("number 0x%0h arrived with nothing expected",
					result_bus.value));
			end else begin
				want = expected_numbers.pop_front();
				if (result_bus.value !== want.value) begin
					report_mismatch($sformatf("number %0d value 0x%0h, expected 0x%0h",
						numbers_checked, result_bus.value, want.value));
				end
				if (result_bus.radix_code !== want.radix_code) begin
					report_mismatch($sformatf("number %0d radix code %0d, expected %0d",
						numbers_checked, result_bus.radix_code, want.radix_code));
				end
				if (result_bus.illegal_seen !== want.illegal_seen) begin
					report_mismatch($sformatf("number %0d illegal flag %0b, expected %0b",
						numbers_checked, result_bus.illegal_seen, want.illegal_seen));
				end
				if (want.radix_code <= RADIX_HEX) begin
					radix_tally[want.radix_code]++;
				end
			end
			numbers_checked++;
		end
	end

	// Result side: random stalls with quiet stretches in between, and once a long hold-off
	// while the sender keeps going, so the result register fills and the input backs up.
	initial begin : drive_result_ready
		int unsigned stall_left;
		int unsigned quiet_left;
		bit          held_off;
		stall_left = 0;
		quiet_left = 0;
		held_off = 1'b0;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && chars_taken >= HOLD_AT) begin
				held_off = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				if (quiet_left > 0) begin
					quiet_left--;
				end else if ($urandom_range(0, 99) < 10) begin
					quiet_left = $urandom_range(20, 80);
				end else if ($urandom_range(0, 99) < 35) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// A run with no transaction on either side for too long has hung.
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (chars_bus.valid && chars_bus.ready) ||
				(result_bus.valid && result_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("watchdog: no transaction for %0d cycles, %0d numbers still expected",
			STALL_LIMIT, expected_numbers.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// Character side: reset, then the directed rows and the random strings, each character
	// offered after a random gap and held until the block takes it. Halfway through, the
	// sender stops until every number it has caused has come out.
	initial begin : drive_chars
		int unsigned gap;
		int unsigned quiet_left;
		int unsigned pause_at;
		arst_n <= 1'b0;
		chars_bus.valid <= 1'b0;
		chars_bus.character <= CH_NUL;
		pred_acc = '0;
		pred_phase = PH_START;
		pred_illegal = 1'b0;
		chars_taken = 0;
		numbers_checked = 0;
		error_count = 0;
		quiet_left = 0;
		for (int i = 0; i < 3; i++) begin
			radix_tally[i] = 0;
		end
		for (int i = 0; i < 22; i++) begin
			char_stream.push_back(DIRECTED_ROWS[i]);
		end
		while (char_stream.size() < 22 + RANDOM_CHARS) begin
			add_random_string();
		end
		pause_at = char_stream.size() / 2;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int idx = 0; idx < char_stream.size(); idx++) begin
			gap = 0;
			if (quiet_left > 0) begin
				quiet_left--;
			end else if ($urandom_range(0, 99) < 8) begin
				quiet_left = $urandom_range(20, 80);
			end else begin
				gap = pick_gap();
			end
			if (idx == pause_at || gap > 0) begin
				chars_bus.valid <= 1'b0;
				if (idx == pause_at) begin
					// Wait on the clock before polling, so the last accepted NUL has reached the queue.
					@(posedge clk);
					while (expected_numbers.size() != 0) @(posedge clk);
				end
				repeat (gap) @(posedge clk);
			end
			chars_bus.valid <= 1'b1;
			chars_bus.character <= char_stream[idx].ch;
			@(posedge clk);
			while (!chars_bus.ready) @(posedge clk);
		end
		chars_bus.valid <= 1'b0;

		// Drain: wait on the clock before polling so the last accepted NUL has reached the queue;
		// its number is offered once the NUL has passed the input stage.
		@(posedge clk);
		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d characters and checked %0d numbers: %0d decimal, %0d octal, %0d hex",
			chars_taken, numbers_checked, radix_tally[RADIX_DEC], radix_tally[RADIX_OCT],
			radix_tally[RADIX_HEX]);
		$display("covered prefixes, illegal and high bytes, overflow, long stalls: %0d mismatches",
			error_count);
		if (error_count == 0 && expected_numbers.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/arnp_pkg.sv
rtl/core/arnp_if.sv
rtl/core/arnp_step.sv
rtl/core/auto_radix_number_parser.sv
rtl/core/arnp_checker.sv
bench/tb_top.sv
